// ===== src/logic_term_lexer_core_defines.svh =====
// ---------------------------------------------------------------------------
// logic_term_lexer_core_defines
// assertion macros for the lexer core, empty when ASSERT_OFF is set
// ---------------------------------------------------------------------------
`ifndef LOGIC_TERM_LEXER_CORE_DEFINES_SVH
`define LOGIC_TERM_LEXER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define LTL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define LTL_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define LTL_ASSERT_ALWAYS(lbl, prop, msg)
`define LTL_ASSERT_IMPLY(lbl, pre, post, msg)
`endif

`endif

// ===== src/ltl_pkg.sv =====
// ---------------------------------------------------------------------------
// ltl_pkg
// shared types, constants and character classes of the lexer core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ltl_pkg;

  localparam int MAX_IDENT_LEN = 127;
  localparam int LEN_W         = 7;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  typedef enum logic [3:0] {
    K_OPEN   = 4'd0,
    K_CLOSE  = 4'd1,
    K_COMMA  = 4'd2,
    K_PERIOD = 4'd3,
    K_ARROW  = 4'd4,
    K_CONST  = 4'd5,
    K_VAR    = 4'd6,
    K_IDEND  = 4'd7,
    K_ERROR  = 4'd8,
    K_END    = 4'd9
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       first;
  } tok_t;

  typedef struct packed {
    tok_t tok0;
    tok_t tok1;
    logic two;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qport_t;

  function automatic tok_t mk_tok(kind_t kind, logic [7:0] ch, logic first);
    tok_t t;
    t.kind  = kind;
    t.ch    = ch;
    t.first = first;
    return t;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_upper(logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_upper(c) || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h30) && (c <= 8'h39));
  endfunction

endpackage

`default_nettype wire

// ===== src/ltl_if.sv =====
// ---------------------------------------------------------------------------
// ltl_if
// channel interfaces: source bytes, tokens and the configuration write
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ltl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       end_of_input;
  modport source (output valid, byte_req, end_of_input, input ready);
  modport sink   (input valid, byte_req, end_of_input, output ready);
endinterface

interface ltl_token_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] lexeme_char;
  logic       first_char;
  logic       last;
  modport source (output valid, token_kind, lexeme_char, first_char, last, input ready);
  modport sink   (input valid, token_kind, lexeme_char, first_char, last, output ready);
endinterface

interface ltl_cfg_if;
  logic valid;
  logic ready;
  logic stop_at_period;
  modport source (output valid, stop_at_period, input ready);
  modport sink   (input valid, stop_at_period, output ready);
endinterface

`default_nettype wire

// ===== src/ltl_front.sv =====
// ---------------------------------------------------------------------------
// ltl_front
// accepts bytes, runs the lexer state and pushes up to two tokens per item
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ltl_front
  import ltl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  ltl_byte_if.sink         byte_in,
  ltl_cfg_if.sink          cfg,
  input  wire logic        q_full,
  output qport_t           push
);

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_IDENT   = 3'd1,
    M_COLON   = 3'd2,
    M_COMMENT = 3'd3,
    M_HALT    = 3'd4
  } mode_t;

  mode_t            mode, mode_next, idle_mode;
  logic [LEN_W-1:0] len, len_next, idle_len;
  logic             is_var, var_next, idle_var;
  logic             stop_at_period;
  logic             idle_emit;
  tok_t             idle_tok, t0, t1;
  logic [1:0]       cnt;
  logic [7:0]       c;
  logic             accept;

  assign c             = byte_in.byte_req;
  assign byte_in.ready = !q_full;
  assign accept        = byte_in.valid && byte_in.ready;
  assign cfg.ready     = 1'b1;

  // lexing of one byte from idle
  always_comb begin
    idle_emit = 1'b0;
    idle_tok  = mk_tok(K_OPEN, 8'h00, 1'b0);
    idle_mode = M_IDLE;
    idle_len  = len;
    idle_var  = is_var;
    priority if (is_space(c)) begin
    end else if (c == CH_OPEN) begin
      idle_emit = 1'b1;
    end else if (c == CH_CLOSE) begin
      idle_emit = 1'b1;
      idle_tok  = mk_tok(K_CLOSE, 8'h00, 1'b0);
    end else if (c == CH_COMMA) begin
      idle_emit = 1'b1;
      idle_tok  = mk_tok(K_COMMA, 8'h00, 1'b0);
    end else if (c == CH_PERIOD) begin
      idle_emit = 1'b1;
      idle_tok  = mk_tok(K_PERIOD, 8'h00, 1'b0);
      idle_mode = stop_at_period ? M_HALT : M_IDLE;
    end else if (c == CH_COLON) begin
      idle_mode = M_COLON;
    end else if (c == CH_PERCENT) begin
      idle_mode = M_COMMENT;
    end else if (is_alnum(c)) begin
      idle_emit = 1'b1;
      idle_var  = is_upper(c);
      idle_len  = LEN_W'(1);
      idle_mode = M_IDENT;
      idle_tok  = mk_tok(is_upper(c) ? K_VAR : K_CONST, c, 1'b1);
    end else begin
      idle_emit = 1'b1;
      idle_tok  = mk_tok(K_ERROR, 8'h00, 1'b0);
      idle_mode = M_HALT;
    end
  end

  always_comb begin
    t0        = mk_tok(K_OPEN, 8'h00, 1'b0);
    t1        = mk_tok(K_OPEN, 8'h00, 1'b0);
    cnt       = 2'd0;
    mode_next = mode;
    len_next  = len;
    var_next  = is_var;
    if (byte_in.end_of_input) begin
      mode_next = M_IDLE;
      len_next  = '0;
      var_next  = 1'b0;
      if (mode == M_IDENT || mode == M_COLON) begin
        t0  = mk_tok((mode == M_IDENT) ? K_IDEND : K_ERROR, 8'h00, 1'b0);
        t1  = mk_tok(K_END, 8'h00, 1'b0);
        cnt = 2'd2;
      end else begin
        t0  = mk_tok(K_END, 8'h00, 1'b0);
        cnt = 2'd1;
      end
    end else begin
      unique case (mode)
        M_HALT: begin
        end
        M_COMMENT: begin
          if (c == CH_NEWLINE) begin
            mode_next = M_IDLE;
          end
        end
        M_COLON: begin
          cnt = 2'd1;
          if (c == CH_DASH) begin
            mode_next = M_IDLE;
            t0        = mk_tok(K_ARROW, 8'h00, 1'b0);
          end else begin
            mode_next = M_HALT;
            t0        = mk_tok(K_ERROR, 8'h00, 1'b0);
          end
        end
        M_IDENT: begin
          if (is_alnum(c)) begin
            cnt = 2'd1;
            if (len >= LEN_W'(MAX_IDENT_LEN)) begin
              mode_next = M_HALT;
              t0        = mk_tok(K_ERROR, 8'h00, 1'b0);
            end else begin
              len_next = len + LEN_W'(1);
              t0       = mk_tok(is_var ? K_VAR : K_CONST, c, 1'b0);
            end
          end else begin
            // closing byte is lexed again from idle
            t0        = mk_tok(K_IDEND, 8'h00, 1'b0);
            t1        = idle_tok;
            cnt       = idle_emit ? 2'd2 : 2'd1;
            mode_next = idle_mode;
            len_next  = '0;
            var_next  = 1'b0;
          end
        end
        default: begin
          t0        = idle_tok;
          cnt       = {1'b0, idle_emit};
          mode_next = idle_mode;
          len_next  = idle_len;
          var_next  = idle_var;
        end
      endcase
    end
  end

  assign push.valid      = accept && (cnt != 2'd0);
  assign push.entry.tok0 = t0;
  assign push.entry.tok1 = t1;
  assign push.entry.two  = (cnt == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= M_IDLE;
      len            <= '0;
      is_var         <= 1'b0;
      stop_at_period <= 1'b0;
    end else begin
      if (accept) begin
        mode   <= mode_next;
        len    <= len_next;
        is_var <= var_next;
      end
      if (cfg.valid && cfg.ready) begin
        stop_at_period <= cfg.stop_at_period;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ltl_queue.sv =====
// ---------------------------------------------------------------------------
// ltl_queue
// short queue of token pairs between the front and the back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ltl_queue
  import ltl_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  qport_t    push,
  output logic      full,
  output qport_t    head,
  input  wire logic pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = mem[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ltl_back.sv =====
// ---------------------------------------------------------------------------
// ltl_back
// splits queued token pairs into single items behind an output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ltl_back
  import ltl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  qport_t           head,
  output logic             pop,
  ltl_token_if.source      token_out
);

  logic out_valid;
  tok_t out_tok;
  logic out_last;
  logic second;
  logic advance;

  assign advance = !out_valid || token_out.ready;
  assign pop     = advance && head.valid && (!head.entry.two || second);

  assign token_out.valid       = out_valid;
  assign token_out.token_kind  = out_tok.kind;
  assign token_out.lexeme_char = out_tok.ch;
  assign token_out.first_char  = out_tok.first;
  assign token_out.last        = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (advance) begin
      out_valid <= head.valid;
      if (head.valid) begin
        second <= head.entry.two && !second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head.valid) begin
      out_tok  <= second ? head.entry.tok1 : head.entry.tok0;
      out_last <= second || !head.entry.two;
    end
  end

endmodule

`default_nettype wire

// ===== src/logic_term_lexer_core.sv =====
// ---------------------------------------------------------------------------
// logic_term_lexer_core
// streaming lexer for logic-program source text, one byte per item
// ---------------------------------------------------------------------------
//  channel     dir  payload                                      handshake
//  byte_in     in   byte_req, end_of_input                       valid/ready
//  token_out   out  token_kind, lexeme_char, first_char, last    valid/ready
//  cfg         in   stop_at_period                               valid/ready
//
//  one byte accepted per cycle while the queue has room; lexer state updates in that same cycle
//  items giving two tokens leave one token at a time, first then second, via the output register
//  token pairs wait in a QUEUE_DEPTH entry queue, byte_in stalls when it fills
//  synchronous reset clears lexer state, queue and output valid
//  tokens pass through a queue entry and then the output register, even at the earliest
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "logic_term_lexer_core_defines.svh"

module logic_term_lexer_core
  import ltl_pkg::*;
#(
  parameter int QUEUE_DEPTH = ltl_pkg::QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ltl_byte_if.sink    byte_in,
  ltl_token_if.source token_out,
  ltl_cfg_if.sink     cfg
);

  qport_t push, head;
  logic   q_full, pop;

  ltl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .cfg     (cfg),
    .q_full  (q_full),
    .push    (push)
  );

  ltl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  ltl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .token_out (token_out)
  );

  `LTL_ASSERT_IMPLY(a_ready_when_room, !q_full, byte_in.ready, "byte_in stalled with queue room")
  `LTL_ASSERT_IMPLY(a_first_is_ident, token_out.valid && token_out.first_char, (token_out.token_kind == K_CONST) || (token_out.token_kind == K_VAR), "first_char on non identifier item")
  `LTL_ASSERT_IMPLY(a_end_is_last, token_out.valid && (token_out.token_kind == K_END), token_out.last, "stream end item without last")
  `LTL_ASSERT_ALWAYS(a_push_needs_room, !(push.valid && q_full), "token pushed into full queue")

endmodule

`default_nettype wire
